>>> sv/assert_macros.svh
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
    else $error("assertion failed");

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> sv/ccbe_pkg.sv
// Types and constants of the battery emulator.
package ccbe_pkg;

  localparam int DW = 64;

  localparam logic [19:0] NOM_V_RST  = 20'd48000;
  localparam logic [19:0] MAX_V_RST  = 20'd54000;
  localparam logic [19:0] MIN_V_RST  = 20'd42000;
  localparam logic [19:0] RATED_RST  = 20'd10000;
  localparam logic [23:0] E_LOW_RST  = 24'd900;
  localparam logic [23:0] E_HIGH_RST = 24'd1000;
  localparam logic [16:0] SOC_RST    = 17'd32768;
  localparam logic [16:0] ONE_Q16    = 17'd65536;

  localparam logic signed [DW-1:0] DEN_SCALE = 64'sd3515625;
  localparam logic [DW-1:0]        SAT_Q     = 64'h4000_0000_0000_0000;

  typedef enum logic [2:0] {
    CFG_NOM_V   = 3'd0,
    CFG_MAX_V   = 3'd1,
    CFG_MIN_V   = 3'd2,
    CFG_RATED   = 3'd3,
    CFG_CH_LOW  = 3'd4,
    CFG_CH_HIGH = 3'd5,
    CFG_DI_LOW  = 3'd6,
    CFG_DI_HIGH = 3'd7
  } cfg_idx_t;

  typedef enum logic [2:0] {
    M_IDLE      = 3'd0,
    M_CH_ENTRY  = 3'd1,
    M_CC_CH     = 3'd2,
    M_CV_CH     = 3'd3,
    M_DIS_ENTRY = 3'd4,
    M_CC_DIS    = 3'd5,
    M_CV_DIS    = 3'd6
  } mode_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DECIDE,
    S_V1, S_V2, S_V3, S_V4, S_V5,
    S_C1, S_C2, S_C3,
    S_E1, S_E2, S_E3, S_E4,
    S_OUT
  } seq_state_t;

  typedef struct packed {
    logic start;
    logic is_div;
  } alu_req_t;

endpackage

>>> sv/cc_cv_battery_emulator.sv
// Top level: CC/CV battery emulator sequencer around a bit-serial mul/div unit.
//
// Input beats on in_*: in_tuser selects the kind (0 set current, 1 tick),
// in_tdata carries the commanded current and the elapsed seconds. Every
// beat gives exactly one output beat on out_* with mode, terminal voltage,
// current and state of charge after the beat.
// Configuration registers are written through cfg_we/cfg_index/cfg_wdata;
// the user must write them only while the block is idle, which the block
// itself does not enforce; they take effect on the next beat.
// One beat is worked at a time. A set-current beat goes through S_OUT to the
// output register. A tick runs up to 8 serial multiplications and 4 divisions
// on the shared unit: a multiplication runs while its second operand's
// magnitude has bits left, a division through every bit of its numerator.
// The serial unit works one bit per cycle.
// After reset the mode is idle, the voltage is the nominal reset value,
// the current zero and the charge one half.
// When the receiver stalls, the finished result waits in the output
// register; a beat may be accepted meanwhile, and its result then waits
// in the sequencer until the output register frees.
`include "assert_macros.svh"
module cc_cv_battery_emulator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // commanded_current[20:0], elapsed_seconds[36:21]
  input  logic        in_tuser,   // op
  output logic        out_tvalid,
  input  logic        out_tready,
  // mode[2:0], terminal_voltage[22:3], battery_current[43:23], charge_fraction[60:44]
  output logic [63:0] out_tdata,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_wdata
);
  import ccbe_pkg::*;

  logic [19:0] nom_v_r, max_v_r, min_v_r, rated_r;
  logic [23:0] ch_low_r, ch_high_r, di_low_r, di_high_r;

  seq_state_t        state_r, state_nxt;
  mode_t             mode_r, mode_nxt;
  logic [19:0]       volt_r, volt_nxt;
  logic [20:0]       cur_r, cur_nxt;
  logic [16:0]       soc_r, soc_nxt;
  logic              busy_r, busy_nxt, ch_r, ch_nxt;
  logic signed [DW-1:0] t0_r, t0_nxt, t1_r, t1_nxt;
  logic [15:0]       dt_r, dt_nxt;
  logic              out_tvalid_r, out_tvalid_nxt;
  logic [63:0]       out_tdata_r, out_tdata_nxt;

  alu_req_t             alu_req;
  logic signed [DW-1:0] alu_a, alu_b, alu_res;
  logic                 alu_done;

  logic [23:0]          e_sel, l_sel;
  logic signed [DW-1:0] e64, le, cur64, i_dir, sv, diffv, base, rated64, tmp;
  logic [19:0]          v_cl;
  logic                 in_acc;

  function automatic logic [19:0] clamp_v(input logic signed [DW-1:0] v,
                                          input logic [19:0] hi, input logic [19:0] lo);
    if (v > $signed({44'd0, hi})) return hi;
    else if (v < $signed({44'd0, lo})) return lo;
    else return v[19:0];
  endfunction

  function automatic logic [20:0] clamp_i(input logic signed [DW-1:0] i,
                                          input logic [19:0] r);
    logic signed [DW-1:0] rr;
    rr = $signed({44'd0, r});
    if (i > rr) return {1'b0, r};
    else if (i < -rr) return 21'(-rr);
    else return i[20:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nom_v_r   <= NOM_V_RST;
      max_v_r   <= MAX_V_RST;
      min_v_r   <= MIN_V_RST;
      rated_r   <= RATED_RST;
      ch_low_r  <= E_LOW_RST;
      ch_high_r <= E_HIGH_RST;
      di_low_r  <= E_LOW_RST;
      di_high_r <= E_HIGH_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_NOM_V:   nom_v_r   <= cfg_wdata[19:0];
        CFG_MAX_V:   max_v_r   <= cfg_wdata[19:0];
        CFG_MIN_V:   min_v_r   <= cfg_wdata[19:0];
        CFG_RATED:   rated_r   <= cfg_wdata[19:0];
        CFG_CH_LOW:  ch_low_r  <= cfg_wdata;
        CFG_CH_HIGH: ch_high_r <= cfg_wdata;
        CFG_DI_LOW:  di_low_r  <= cfg_wdata;
        CFG_DI_HIGH: di_high_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      mode_r       <= M_IDLE;
      volt_r       <= NOM_V_RST;
      cur_r        <= '0;
      soc_r        <= SOC_RST;
      busy_r       <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      mode_r       <= mode_nxt;
      volt_r       <= volt_nxt;
      cur_r        <= cur_nxt;
      soc_r        <= soc_nxt;
      busy_r       <= busy_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
    ch_r        <= ch_nxt;
    t0_r        <= t0_nxt;
    t1_r        <= t1_nxt;
    dt_r        <= dt_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  // operands of the law being worked, picked by direction
  always_comb begin
    e_sel   = ch_r ? ch_high_r : di_high_r;
    l_sel   = ch_r ? ch_low_r : di_low_r;
    e64     = $signed({40'd0, e_sel});
    le      = $signed({40'd0, l_sel}) - e64;
    cur64   = {{43{cur_r[20]}}, cur_r};
    i_dir   = ch_r ? cur64 : -cur64;
    sv      = ch_r ? $signed({47'd0, soc_r}) : $signed({47'd0, ONE_Q16}) - $signed({47'd0, soc_r});
    diffv   = ch_r ? $signed({44'd0, max_v_r}) - $signed({44'd0, nom_v_r})
                   : $signed({44'd0, min_v_r}) - $signed({44'd0, max_v_r});
    base    = ch_r ? $signed({44'd0, nom_v_r}) : $signed({44'd0, max_v_r});
    rated64 = $signed({44'd0, rated_r});
  end

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    volt_nxt       = volt_r;
    cur_nxt        = cur_r;
    soc_nxt        = soc_r;
    busy_nxt       = busy_r;
    ch_nxt         = ch_r;
    t0_nxt         = t0_r;
    t1_nxt         = t1_r;
    dt_nxt         = dt_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    alu_req        = '0;
    alu_a          = '0;
    alu_b          = '0;
    tmp            = '0;
    v_cl           = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (!in_tuser) begin
            cur_nxt   = clamp_i({{43{in_tdata[20]}}, in_tdata[20:0]}, rated_r);
            state_nxt = S_OUT;
          end else begin
            dt_nxt    = in_tdata[36:21];
            state_nxt = S_DECIDE;
          end
        end
      end
      S_DECIDE: begin
        unique case (mode_r)
          M_CH_ENTRY, M_CC_CH: begin
            ch_nxt = 1'b1;
            if (mode_r == M_CC_CH && cur_r == '0) begin
              mode_nxt  = M_IDLE;
              state_nxt = S_E1;
            end else state_nxt = S_V1;
          end
          M_CV_CH: begin
            ch_nxt = 1'b1;
            if (cur_r == '0) begin
              mode_nxt  = M_IDLE;
              state_nxt = S_E1;
            end else state_nxt = S_C1;
          end
          M_DIS_ENTRY, M_CC_DIS: begin
            ch_nxt = 1'b0;
            if (mode_r == M_CC_DIS && cur_r == '0) begin
              mode_nxt  = M_IDLE;
              state_nxt = S_E1;
            end else state_nxt = S_V1;
          end
          M_CV_DIS: begin
            ch_nxt = 1'b0;
            if (cur_r == '0) begin
              mode_nxt  = M_IDLE;
              state_nxt = S_E1;
            end else state_nxt = S_C1;
          end
          default: begin
            if (cur_r == '0) mode_nxt = M_IDLE;
            else if (cur_r[20]) mode_nxt = M_DIS_ENTRY;
            else mode_nxt = M_CH_ENTRY;
            state_nxt = S_E1;
          end
        endcase
      end
      S_OUT: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {3'd0, soc_r, cur_r, volt_r, 3'(mode_r)};
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        // arithmetic steps: issue to the serial unit, then take its result
        unique case (state_r)
          S_V1: begin alu_a = i_dir; alu_b = le; end
          S_V2: begin alu_a = t0_r <<< 16; alu_b = rated64; alu_req.is_div = 1'b1; end
          S_V3: begin alu_a = sv; alu_b = e64; end
          S_V4: begin alu_a = t1_r; alu_b = diffv; end
          S_V5: begin alu_a = t1_r; alu_b = t0_r; alu_req.is_div = 1'b1; end
          S_C1: begin alu_a = sv; alu_b = e64; end
          S_C2: begin alu_a = rated64; alu_b = t1_r; end
          S_C3: begin alu_a = t1_r; alu_b = le <<< 16; alu_req.is_div = 1'b1; end
          S_E1: begin alu_a = $signed({44'd0, volt_r}); alu_b = cur64; end
          // capacity picked on the sign of the power itself
          S_E2: begin
            alu_a = DEN_SCALE;
            alu_b = (t0_r > 0) ? $signed({40'd0, ch_high_r}) : $signed({40'd0, di_high_r});
          end
          S_E3: begin alu_a = t0_r; alu_b = $signed({42'd0, dt_r, 6'd0}); end
          S_E4: begin alu_a = t0_r; alu_b = t1_r; alu_req.is_div = 1'b1; end
          default: ;
        endcase
        if (!busy_r) begin
          alu_req.start = 1'b1;
          busy_nxt      = 1'b1;
        end else if (alu_done) begin
          busy_nxt = 1'b0;
          unique case (state_r)
            S_V1: begin t0_nxt = alu_res; state_nxt = S_V2; end
            S_V2: begin t0_nxt = (e64 <<< 16) + alu_res; state_nxt = S_V3; end
            S_V3: begin t1_nxt = alu_res; state_nxt = S_V4; end
            S_V4: begin t1_nxt = alu_res; state_nxt = S_V5; end
            S_V5: begin
              v_cl     = clamp_v(base + alu_res, max_v_r, min_v_r);
              volt_nxt = v_cl;
              if (ch_r ? (v_cl == max_v_r) : (v_cl == min_v_r)) begin
                mode_nxt  = ch_r ? M_CV_CH : M_CV_DIS;
                state_nxt = S_C1;
              end else begin
                mode_nxt  = ch_r ? M_CC_CH : M_CC_DIS;
                state_nxt = S_E1;
              end
            end
            S_C1: begin t1_nxt = alu_res - (e64 <<< 16); state_nxt = S_C2; end
            S_C2: begin t1_nxt = alu_res; state_nxt = S_C3; end
            S_C3: begin
              cur_nxt   = clamp_i(ch_r ? alu_res : -alu_res, rated_r);
              state_nxt = S_E1;
            end
            S_E1: begin t0_nxt = alu_res; state_nxt = S_E2; end
            S_E2: begin t1_nxt = alu_res; state_nxt = S_E3; end
            S_E3: begin t0_nxt = alu_res; state_nxt = S_E4; end
            S_E4: begin
              tmp = $signed({47'd0, soc_r}) + alu_res;
              if (tmp > $signed({47'd0, ONE_Q16})) soc_nxt = ONE_Q16;
              else if (tmp < 0) soc_nxt = '0;
              else soc_nxt = tmp[16:0];
              state_nxt = S_OUT;
            end
            default: ;
          endcase
        end
      end
    endcase
  end

  ccbe_serial_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (alu_req),
    .op_a  (alu_a),
    .op_b  (alu_b),
    .res   (alu_res),
    .done  (alu_done)
  );

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  `ASSERT_ALWAYS(a_soc_range, clk, rst_n, soc_r <= ONE_Q16)
  `ASSERT_IMPL(a_done_when_busy, clk, rst_n, alu_done, busy_r)
  `ASSERT_NEXT(a_accept_leaves_idle, clk, rst_n, in_acc, state_r != S_IDLE)

endmodule

>>> sv/ccbe_serial_alu.sv
// Bit-serial signed multiplier and restoring divider, one bit per cycle.
`include "assert_macros.svh"
module ccbe_serial_alu (
  input  logic                             clk,
  input  logic                             rst_n,
  input  ccbe_pkg::alu_req_t               req,
  input  logic signed [ccbe_pkg::DW-1:0]   op_a,
  input  logic signed [ccbe_pkg::DW-1:0]   op_b,
  output logic signed [ccbe_pkg::DW-1:0]   res,
  output logic                             done
);
  import ccbe_pkg::*;

  logic [DW-1:0] a_r, a_nxt, b_r, b_nxt, acc_r, acc_nxt, rem_r, rem_nxt, rem_sh, mag;
  logic          neg_r, neg_nxt, div_r, div_nxt, run_r, run_nxt, done_r, done_nxt;
  logic [6:0]    cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    acc_r <= acc_nxt;
    rem_r <= rem_nxt;
    neg_r <= neg_nxt;
    div_r <= div_nxt;
    cnt_r <= cnt_nxt;
  end

  always_comb begin
    a_nxt    = a_r;
    b_nxt    = b_r;
    acc_nxt  = acc_r;
    rem_nxt  = rem_r;
    neg_nxt  = neg_r;
    div_nxt  = div_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    rem_sh   = {rem_r[DW-2:0], a_r[DW-1]};
    if (req.start) begin
      a_nxt   = op_a[DW-1] ? DW'(-op_a) : DW'(op_a);
      b_nxt   = op_b[DW-1] ? DW'(-op_b) : DW'(op_b);
      acc_nxt = '0;
      rem_nxt = '0;
      neg_nxt = op_a[DW-1] ^ op_b[DW-1];
      div_nxt = req.is_div;
      cnt_nxt = 7'(DW);
      if (req.is_div && op_b == '0) begin
        // divide by zero: saturate after the numerator's sign
        a_nxt    = (op_a == '0) ? '0 : SAT_Q;
        neg_nxt  = op_a[DW-1];
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end else begin
        run_nxt = 1'b1;
      end
    end else if (run_r) begin
      if (div_r) begin
        if (rem_sh >= b_r) begin
          rem_nxt = rem_sh - b_r;
          a_nxt   = {a_r[DW-2:0], 1'b1};
        end else begin
          rem_nxt = rem_sh;
          a_nxt   = {a_r[DW-2:0], 1'b0};
        end
        cnt_nxt = cnt_r - 7'd1;
        if (cnt_r == 7'd1) begin
          run_nxt  = 1'b0;
          done_nxt = 1'b1;
        end
      end else if (b_r == '0) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end else begin
        if (b_r[0]) acc_nxt = acc_r + a_r;
        a_nxt = a_r << 1;
        b_nxt = b_r >> 1;
      end
    end
  end

  assign mag  = div_r ? a_r : acc_r;
  assign res  = neg_r ? -$signed(mag) : $signed(mag);
  assign done = done_r;

  `ASSERT_IMPL(a_no_restart, clk, rst_n, req.start, !run_r)
  `ASSERT_NEXT(a_done_pulse, clk, rst_n, done_r, !done_r)
  `ASSERT_IMPL(a_div_count, clk, rst_n, run_r && div_r, cnt_r != 7'd0)

endmodule

>>> test/cc_cv_battery_emulator_checker.sv
// Checker for the battery emulator: tracks the state, predicts each result beat and compares.
`timescale 1ns / 1ps
module cc_cv_battery_emulator_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [39:0] in_tdata,   // commanded_current[20:0], elapsed_seconds[36:21]
  input  logic        in_tuser,   // op
  input  logic        out_tvalid,
  input  logic        out_tready,
  // mode[2:0], terminal_voltage[22:3], battery_current[43:23], charge_fraction[60:44]
  input  logic [63:0] out_tdata,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_wdata,
  output int          fail_count,
  output int          pending
);
  import ccbe_pkg::*;

  typedef struct {
    logic [2:0]  mode;
    logic [19:0] volt;
    logic [20:0] cur;
    logic [16:0] soc;
  } batt_status_t;

  localparam longint SAT   = 64'sh4000_0000_0000_0000;
  localparam longint FULL  = 65536;

  batt_status_t status_q[$];

  longint nom_v, max_v, min_v, rated, ch_low, ch_high, di_low, di_high;
  mode_t  mode_s;
  longint volt_s, cur_s, soc_s;

  assign pending = status_q.size();

  function automatic longint sat_div(longint n, longint d);
    if (d == 0)
      return (n > 0) ? SAT : ((n < 0) ? -SAT : 0);
    return n / d;
  endfunction

  function automatic void drive_voltage(longint v);
    if (v > max_v) volt_s = max_v;
    else if (v < min_v) volt_s = min_v;
    else volt_s = v;
  endfunction

  function automatic void drive_current(longint i);
    if (i > rated) cur_s = rated;
    else if (i < -rated) cur_s = -rated;
    else cur_s = i;
  endfunction

  function automatic void charge_v_law();
    longint ee;
    ee = ch_high * FULL + sat_div(cur_s * (ch_low - ch_high) * FULL, rated);
    drive_voltage(nom_v + sat_div(soc_s * ch_high * (max_v - nom_v), ee));
  endfunction

  function automatic void charge_i_law();
    drive_current(sat_div(rated * (soc_s * ch_high - ch_high * FULL),
                          (ch_low - ch_high) * FULL));
  endfunction

  function automatic void discharge_v_law();
    longint ee;
    ee = di_high * FULL + sat_div((-cur_s) * (di_low - di_high) * FULL, rated);
    drive_voltage(max_v + sat_div((FULL - soc_s) * di_high * (min_v - max_v), ee));
  endfunction

  function automatic void discharge_i_law();
    drive_current(-sat_div(rated * ((FULL - soc_s) * di_high - di_high * FULL),
                           (di_low - di_high) * FULL));
  endfunction

  function automatic void step_mode();
    case (mode_s)
      M_CH_ENTRY, M_CC_CH: begin
        if (mode_s == M_CC_CH && cur_s == 0) begin
          mode_s = M_IDLE;
        end else begin
          charge_v_law();
          if (volt_s == max_v) begin
            charge_i_law();
            mode_s = M_CV_CH;
          end else begin
            mode_s = M_CC_CH;
          end
        end
      end
      M_CV_CH: begin
        if (cur_s == 0) mode_s = M_IDLE;
        else charge_i_law();
      end
      M_DIS_ENTRY, M_CC_DIS: begin
        if (mode_s == M_CC_DIS && cur_s == 0) begin
          mode_s = M_IDLE;
        end else begin
          discharge_v_law();
          if (volt_s == min_v) begin
            discharge_i_law();
            mode_s = M_CV_DIS;
          end else begin
            mode_s = M_CC_DIS;
          end
        end
      end
      M_CV_DIS: begin
        if (cur_s == 0) mode_s = M_IDLE;
        else discharge_i_law();
      end
      default: begin
        if (cur_s > 0) mode_s = M_CH_ENTRY;
        else if (cur_s < 0) mode_s = M_DIS_ENTRY;
        else mode_s = M_IDLE;
      end
    endcase
  endfunction

  function automatic batt_status_t predict_beat(logic op, logic [20:0] cmd, logic [15:0] dt);
    longint p, e, s;
    batt_status_t r;
    if (!op) begin
      drive_current(longint'($signed(cmd)));
    end else begin
      step_mode();
      p = volt_s * cur_s;
      e = (p > 0) ? ch_high : di_high;
      s = soc_s + sat_div(p * longint'(dt) * 64, 64'sd3515625 * e);
      if (s > FULL) s = FULL;
      else if (s < 0) s = 0;
      soc_s = s;
    end
    r.mode = mode_s;
    r.volt = volt_s[19:0];
    r.cur  = cur_s[20:0];
    r.soc  = soc_s[16:0];
    return r;
  endfunction

  always @(posedge clk) begin
    batt_status_t want;
    if (!rst_n) begin
      nom_v = NOM_V_RST; max_v = MAX_V_RST; min_v = MIN_V_RST; rated = RATED_RST;
      ch_low = E_LOW_RST; ch_high = E_HIGH_RST; di_low = E_LOW_RST; di_high = E_HIGH_RST;
      mode_s = M_IDLE; volt_s = NOM_V_RST; cur_s = 0; soc_s = SOC_RST;
      status_q.delete();
      fail_count = 0;
    end else begin
      // result side first: a beat accepted at this edge cannot complete at it
      if (out_tvalid && out_tready) begin
        if (status_q.size() == 0) begin
          $error("result beat with no expectation: %h", out_tdata);
          fail_count++;
        end else begin
          want = status_q.pop_front();
          if (out_tdata[2:0] !== want.mode) begin
            $error("mode: expected %0d, got %0d", want.mode, out_tdata[2:0]);
            fail_count++;
          end
          if (out_tdata[22:3] !== want.volt) begin
            $error("terminal_voltage: expected %0d, got %0d", want.volt, out_tdata[22:3]);
            fail_count++;
          end
          if (out_tdata[43:23] !== want.cur) begin
            $error("battery_current: expected %0d, got %0d",
                   $signed(want.cur), $signed(out_tdata[43:23]));
            fail_count++;
          end
          if (out_tdata[60:44] !== want.soc) begin
            $error("charge_fraction: expected %0d, got %0d", want.soc, out_tdata[60:44]);
            fail_count++;
          end
        end
      end
      if (in_tvalid && in_tready)
        status_q.push_back(predict_beat(in_tuser, in_tdata[20:0], in_tdata[36:21]));
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_NOM_V:   nom_v   = cfg_wdata[19:0];
          CFG_MAX_V:   max_v   = cfg_wdata[19:0];
          CFG_MIN_V:   min_v   = cfg_wdata[19:0];
          CFG_RATED:   rated   = cfg_wdata[19:0];
          CFG_CH_LOW:  ch_low  = cfg_wdata;
          CFG_CH_HIGH: ch_high = cfg_wdata;
          CFG_DI_LOW:  di_low  = cfg_wdata;
          CFG_DI_HIGH: di_high = cfg_wdata;
          default: ;
        endcase
      end
    end
  end

endmodule

>>> test/cc_cv_battery_emulator_tb.sv
// Testbench top for the battery emulator: stimulus, configuration phases and verdict.
`timescale 1ns / 1ps
module cc_cv_battery_emulator_tb;
  import ccbe_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;   // commanded_current[20:0], elapsed_seconds[36:21]
  logic        in_tuser = 1'b0; // op
  logic        out_tvalid;
  logic        out_tready = 1'b1;
  // mode[2:0], terminal_voltage[22:3], battery_current[43:23], charge_fraction[60:44]
  logic [63:0] out_tdata;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = CFG_NOM_V;
  logic [23:0] cfg_wdata = '0;

  int fail_count;
  int pending;
  int burst_left = 0;
  int stall_left = 0;
  int stall_pct = 30;

  localparam logic OP_SET  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  always #5 clk = ~clk;

  cc_cv_battery_emulator u_top (.*);

  cc_cv_battery_emulator_checker u_chk (.*);

  // receiver back-pressure: random stall runs, rate set per phase
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else begin
      out_tready <= 1'b1;
      if ($urandom_range(0, 99) < stall_pct) stall_left = $urandom_range(1, 12);
    end
  end

  task automatic send_beat(logic op, logic [20:0] cmd, logic [15:0] dt);
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
      burst_left = $urandom_range(1, 20);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {3'b000, dt, cmd};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    burst_left--;
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [23:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic load_setting(int unsigned sel);
    logic [19:0] lo_v, hi_v, mid_v;
    lo_v  = 20'($urandom_range(0, 400000));
    hi_v  = lo_v + 20'($urandom_range(1000, 400000));
    mid_v = 20'($urandom_range(lo_v, hi_v));
    case (sel)
      0: begin
        write_reg(CFG_NOM_V, 24'(NOM_V_RST));  write_reg(CFG_MAX_V, 24'(MAX_V_RST));
        write_reg(CFG_MIN_V, 24'(MIN_V_RST));  write_reg(CFG_RATED, 24'(RATED_RST));
        write_reg(CFG_CH_LOW, E_LOW_RST); write_reg(CFG_CH_HIGH, E_HIGH_RST);
        write_reg(CFG_DI_LOW, E_LOW_RST); write_reg(CFG_DI_HIGH, E_HIGH_RST);
      end
      1: begin // widest ranges
        write_reg(CFG_NOM_V, 24'hFFFFF); write_reg(CFG_MAX_V, 24'hFFFFF);
        write_reg(CFG_MIN_V, 24'd0);     write_reg(CFG_RATED, 24'd1000000);
        write_reg(CFG_CH_LOW, 24'd1);    write_reg(CFG_CH_HIGH, 24'hFFFFFF);
        write_reg(CFG_DI_LOW, 24'd1);    write_reg(CFG_DI_HIGH, 24'hFFFFFF);
      end
      2: begin // minimum values, low equals high so the current law divides by zero
        write_reg(CFG_NOM_V, 24'd0);  write_reg(CFG_MAX_V, 24'd0);
        write_reg(CFG_MIN_V, 24'd0);  write_reg(CFG_RATED, 24'd1);
        write_reg(CFG_CH_LOW, 24'd1); write_reg(CFG_CH_HIGH, 24'd1);
        write_reg(CFG_DI_LOW, 24'd1); write_reg(CFG_DI_HIGH, 24'd1);
      end
      3: begin // min above max
        write_reg(CFG_NOM_V, 24'd45000); write_reg(CFG_MAX_V, 24'd40000);
        write_reg(CFG_MIN_V, 24'd50000); write_reg(CFG_RATED, 24'($urandom_range(1, 50000)));
        write_reg(CFG_CH_LOW, 24'hFFFFFF); write_reg(CFG_CH_HIGH, 24'd500);
        write_reg(CFG_DI_LOW, 24'd2000);   write_reg(CFG_DI_HIGH, 24'hFFFFFF);
      end
      default: begin
        write_reg(CFG_NOM_V, 24'(mid_v)); write_reg(CFG_MAX_V, 24'(hi_v));
        write_reg(CFG_MIN_V, 24'(lo_v));  write_reg(CFG_RATED, 24'($urandom_range(1, 1000000)));
        write_reg(CFG_CH_LOW, 24'($urandom_range(1, 5000)));
        write_reg(CFG_CH_HIGH, 24'($urandom_range(1, 20000)));
        write_reg(CFG_DI_LOW, 24'($urandom_range(1, 5000)));
        write_reg(CFG_DI_HIGH, 24'($urandom_range(1, 20000)));
      end
    endcase
  endtask

  function automatic logic [20:0] pick_current(logic [19:0] lim);
    int signed mag;
    case ($urandom_range(0, 5))
      0: return 21'($urandom);
      1: return 21'(0);
      2: begin
        mag = int'($urandom_range(0, 1000000));
        return $urandom_range(0, 1) ? 21'(mag) : 21'(-mag);
      end
      default: begin
        mag = int'($urandom_range(1, (lim > 0) ? lim : 1));
        return $urandom_range(0, 1) ? 21'(mag) : 21'(-mag);
      end
    endcase
  endfunction

  function automatic logic [15:0] pick_dt();
    case ($urandom_range(0, 7))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'($urandom);
      3: return 16'($urandom_range(1, 4000));
      default: return 16'($urandom_range(1, 120));
    endcase
  endfunction

  initial begin
    int sent;
    logic [19:0] lim;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: reset settings, every mode path and field extreme
    send_beat(OP_TICK, 21'd0, 16'd10);        // idle stays idle
    send_beat(OP_SET, 21'(20000), 16'd0);     // clamps to rated
    send_beat(OP_TICK, 21'd0, 16'd0);         // charge entry
    send_beat(OP_TICK, 21'd0, 16'd60);        // CC charge
    send_beat(OP_TICK, 21'd0, 16'hFFFF);      // fills up
    send_beat(OP_TICK, 21'd0, 16'hFFFF);      // CV charge
    send_beat(OP_TICK, 21'd0, 16'd100);
    send_beat(OP_SET, 21'h0FFFFF, 16'd0);     // largest positive
    send_beat(OP_SET, 21'd0, 16'd0);
    send_beat(OP_TICK, 21'd0, 16'd5);         // CV with zero current goes idle
    send_beat(OP_SET, 21'h100000, 16'hFFFF);  // most negative, dt field ignored
    send_beat(OP_TICK, 21'd0, 16'd1);         // discharge entry
    send_beat(OP_TICK, 21'd0, 16'hFFFF);
    send_beat(OP_TICK, 21'd0, 16'hFFFF);      // empties, CV discharge
    send_beat(OP_TICK, 21'h1FFFFF, 16'd30);
    send_beat(OP_SET, 21'(-1), 16'd0);
    send_beat(OP_TICK, 21'd0, 16'd30);
    send_beat(OP_SET, 21'(1), 16'd0);
    send_beat(OP_TICK, 21'd0, 16'd30);
    send_beat(OP_SET, 21'd0, 16'd0);
    send_beat(OP_TICK, 21'd0, 16'd1);
    send_beat(OP_TICK, 21'd0, 16'd1);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      load_setting((ph == 5) ? 0 : ((ph + 1) % 5));
      lim = (ph == 2) ? 20'd1000000 : 20'd60000;
      stall_pct = (ph == 3) ? 0 : $urandom_range(5, 60);
      sent = 0;
      while (sent < 340) begin
        if ($urandom_range(0, 99) < 85) begin
          send_beat(OP_SET, pick_current(lim), 16'($urandom));
          sent++;
          repeat ($urandom_range(1, 8)) begin
            send_beat(OP_TICK, 21'($urandom), pick_dt());
            sent++;
          end
        end else begin
          send_beat(1'($urandom), 21'($urandom), 16'($urandom));
          sent++;
        end
      end
      drain();
    end

    repeat (50) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
